// ----- hw/rtl/rti_pkg.sv -----
// ----------------------------------------------------------------------------
// rti_pkg
// Shared types and constants for the ray / triangle intersection pipeline.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int DEF_COORD_FRAC_BITS = 16;
  localparam int MAX_COORD_FRAC_BITS = 24;
  localparam int COORD_W   = 32;
  localparam int DOT_W     = 102;
  localparam int REM_W     = 132;
  localparam int T_BITS    = 31;
  localparam int WT_FRAC   = 16;
  localparam int WT_BITS   = 17;
  localparam int DIV_STAGES = 31;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_PARALLEL = 3'd1;
  localparam logic [2:0] ST_U_OUT    = 3'd2;
  localparam logic [2:0] ST_V_OUT    = 3'd3;
  localparam logic [2:0] ST_BEHIND   = 3'd4;

  localparam logic [2:0] REG_V0_XY  = 3'd0;
  localparam logic [2:0] REG_V0_Z   = 3'd1;
  localparam logic [2:0] REG_V1_XY  = 3'd2;
  localparam logic [2:0] REG_V1_Z   = 3'd3;
  localparam logic [2:0] REG_V2_XY  = 3'd4;
  localparam logic [2:0] REG_V2_Z   = 3'd5;
  localparam logic [2:0] REG_DET_EPS = 3'd6;
  localparam logic [2:0] REG_T_EPS  = 3'd7;

  typedef struct packed {
    logic [2:0]         status;
    logic               sat;
    logic [REM_W-1:0]   a;
    logic [REM_W-1:0]   rem_t;
    logic [REM_W-1:0]   rem_u;
    logic [REM_W-1:0]   rem_v;
    logic [T_BITS-1:0]  q_t;
    logic [WT_BITS-1:0] q_u;
    logic [WT_BITS-1:0] q_v;
  } div_t;

endpackage

// ----- hw/rtl/rti_div_stage.sv -----
// ----------------------------------------------------------------------------
// rti_div_stage
// One restoring division step at quotient bit K for t, and for u and v when K < WT_BITS, registered.
// ----------------------------------------------------------------------------
module rti_div_stage import rti_pkg::*; #(
  parameter int K = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic din_valid,
  input  div_t din,
  output logic dout_valid,
  output div_t dout
);

  div_t nxt;
  logic [REM_W-1:0] dsh;

  always_comb begin
    nxt = din;
    dsh = din.a << K;
    if (din.rem_t >= dsh) begin
      nxt.rem_t = din.rem_t - dsh;
      nxt.q_t[K] = 1'b1;
    end
    if (K < WT_BITS) begin
      if (din.rem_u >= dsh) begin
        nxt.rem_u = din.rem_u - dsh;
        nxt.q_u[K % WT_BITS] = 1'b1;
      end
      if (din.rem_v >= dsh) begin
        nxt.rem_v = din.rem_v - dsh;
        nxt.q_v[K % WT_BITS] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout_valid <= 1'b0;
    end else if (adv) begin
      dout_valid <= din_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dout <= nxt;
    end
  end

endmodule

// ----- hw/rtl/ray_triangle_intersect.sv -----
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Moller-Trumbore ray / triangle test, fixed point, exact wide products,
// one ray per beat against a triangle held in configuration registers.
// ----------------------------------------------------------------------------
// Pipeline: 8 product/compare stages, 31 division stages, output register.
// Throughput: one ray per cycle while the skid slot is empty; one bit per divider stage.
// Stalls freeze the whole pipe only once the output skid slot is full.
// Reset clears all valid bits; vertices reset to 0, both epsilons to 1.
// ----------------------------------------------------------------------------
module ray_triangle_intersect import rti_pkg::*; #(
  parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] origin_z,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic signed [31:0] dir_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic signed [31:0] hit_distance,
  output logic [16:0]        weight_u,
  output logic [16:0]        weight_v
);

  localparam int NXT [3] = '{1, 2, 0};
  localparam int PRV [3] = '{2, 0, 1};

  // configuration
  logic [63:0] v0_xy, v1_xy, v2_xy;
  logic [31:0] v0_z, v1_z, v2_z, det_eps;
  logic [30:0] t_eps;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0_xy <= '0; v0_z <= '0;
      v1_xy <= '0; v1_z <= '0;
      v2_xy <= '0; v2_z <= '0;
      det_eps <= 32'd1;
      t_eps <= 31'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_V0_XY:   v0_xy <= cfg_data;
        REG_V0_Z:    v0_z <= cfg_data[31:0];
        REG_V1_XY:   v1_xy <= cfg_data;
        REG_V1_Z:    v1_z <= cfg_data[31:0];
        REG_V2_XY:   v2_xy <= cfg_data;
        REG_V2_Z:    v2_z <= cfg_data[31:0];
        REG_DET_EPS: det_eps <= cfg_data[31:0];
        REG_T_EPS:   t_eps <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  logic [31:0] p0 [3];
  logic [31:0] p1 [3];
  logic [31:0] p2 [3];
  logic [31:0] ori [3];
  logic [31:0] dir [3];

  always_comb begin
    p0[0] = v0_xy[63:32]; p0[1] = v0_xy[31:0]; p0[2] = v0_z;
    p1[0] = v1_xy[63:32]; p1[1] = v1_xy[31:0]; p1[2] = v1_z;
    p2[0] = v2_xy[63:32]; p2[1] = v2_xy[31:0]; p2[2] = v2_z;
    ori[0] = origin_x; ori[1] = origin_y; ori[2] = origin_z;
    dir[0] = dir_x; dir[1] = dir_y; dir[2] = dir_z;
  end

  logic signed [32:0] e1 [3];
  logic signed [32:0] e2 [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      e1[i] <= {p1[i][31], p1[i]} - {p0[i][31], p0[i]};
      e2[i] <= {p2[i][31], p2[i]} - {p0[i][31], p0[i]};
    end
  end

  // pipeline control
  logic adv;
  logic v0, v1, v2, v3, v4, v5, v6;
  logic dvv [DIV_STAGES+1];
  div_t dv  [DIV_STAGES+1];

  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0; v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
      v1 <= v0; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5;
    end
  end

  // stage 0: s = O - V0
  logic signed [32:0] s0_s [3];
  logic signed [31:0] s0_d [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s0_s[i] <= {ori[i][31], ori[i]} - {p0[i][31], p0[i]};
        s0_d[i] <= dir[i];
      end
    end
  end

  // stage 1: cross product terms
  logic signed [64:0] hp [3];
  logic signed [64:0] hn [3];
  logic signed [65:0] qp [3];
  logic signed [65:0] qn [3];
  logic signed [32:0] s1_s [3];
  logic signed [31:0] s1_d [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        hp[i] <= s0_d[NXT[i]] * e2[PRV[i]];
        hn[i] <= s0_d[PRV[i]] * e2[NXT[i]];
        qp[i] <= s0_s[NXT[i]] * e1[PRV[i]];
        qn[i] <= s0_s[PRV[i]] * e1[NXT[i]];
        s1_s[i] <= s0_s[i];
        s1_d[i] <= s0_d[i];
      end
    end
  end

  // stage 2: h = D x e2, q = s x e1
  logic signed [65:0] h2 [3];
  logic signed [66:0] q2 [3];
  logic signed [32:0] s2_s [3];
  logic signed [31:0] s2_d [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        h2[i] <= hp[i] - hn[i];
        q2[i] <= qp[i] - qn[i];
        s2_s[i] <= s1_s[i];
        s2_d[i] <= s1_d[i];
      end
    end
  end

  // stage 3: partial products, wide operand split at bit 33
  logic signed [32:0] hh [3];
  logic signed [33:0] hl [3];
  logic signed [33:0] qh [3];
  logic signed [33:0] ql [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hh[i] = $signed(h2[i][65:33]);
      hl[i] = $signed({1'b0, h2[i][32:0]});
      qh[i] = $signed(q2[i][66:33]);
      ql[i] = $signed({1'b0, q2[i][32:0]});
    end
  end

  logic signed [66:0] a_hi [3];
  logic signed [66:0] a_lo [3];
  logic signed [66:0] u_hi [3];
  logic signed [66:0] u_lo [3];
  logic signed [66:0] v_hi [3];
  logic signed [66:0] v_lo [3];
  logic signed [66:0] t_hi [3];
  logic signed [66:0] t_lo [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a_hi[i] <= e1[i] * hh[i];
        a_lo[i] <= e1[i] * hl[i];
        u_hi[i] <= s2_s[i] * hh[i];
        u_lo[i] <= s2_s[i] * hl[i];
        v_hi[i] <= s2_d[i] * qh[i];
        v_lo[i] <= s2_d[i] * ql[i];
        t_hi[i] <= e2[i] * qh[i];
        t_lo[i] <= e2[i] * ql[i];
      end
    end
  end

  // stage 4: recombine partials
  logic signed [DOT_W-1:0] pa [3];
  logic signed [DOT_W-1:0] pu [3];
  logic signed [DOT_W-1:0] pv [3];
  logic signed [DOT_W-1:0] pt [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pa[i] <= (a_hi[i] <<< 33) + a_lo[i];
        pu[i] <= (u_hi[i] <<< 33) + u_lo[i];
        pv[i] <= (v_hi[i] <<< 33) + v_lo[i];
        pt[i] <= (t_hi[i] <<< 33) + t_lo[i];
      end
    end
  end

  // stage 5: dot products
  logic signed [DOT_W-1:0] a5, nu5, nv5, nt5;
  always_ff @(posedge clk) begin
    if (adv) begin
      a5  <= pa[0] + pa[1] + pa[2];
      nu5 <= pu[0] + pu[1] + pu[2];
      nv5 <= pv[0] + pv[1] + pv[2];
      nt5 <= pt[0] + pt[1] + pt[2];
    end
  end

  // stage 6: make the determinant positive
  logic signed [DOT_W-1:0] a6, nu6, nv6, nt6;
  always_ff @(posedge clk) begin
    if (adv) begin
      if (a5[DOT_W-1]) begin
        a6 <= -a5; nu6 <= -nu5; nv6 <= -nv5; nt6 <= -nt5;
      end else begin
        a6 <= a5; nu6 <= nu5; nv6 <= nv5; nt6 <= nt5;
      end
    end
  end

  // stage 7: range tests, divider setup
  localparam int PAD = REM_W - DOT_W;
  logic signed [DOT_W:0] uv_sum;
  logic [REM_W-1:0] a_ext, nt_ext;
  div_t init;

  always_comb begin
    uv_sum = nu6 + nv6;
    a_ext  = {{PAD{1'b0}}, a6};
    nt_ext = {{PAD{1'b0}}, nt6};
    init.a     = a_ext;
    init.rem_t = nt_ext << COORD_FRAC_BITS;
    init.rem_u = {{PAD{1'b0}}, nu6} << WT_FRAC;
    init.rem_v = {{PAD{1'b0}}, nv6} << WT_FRAC;
    init.sat   = nt_ext >= (a_ext << (T_BITS - COORD_FRAC_BITS));
    init.q_t   = '0;
    init.q_u   = '0;
    init.q_v   = '0;
    if (a6 == '0 || a6 < $signed({{(DOT_W-32){1'b0}}, det_eps})) begin
      init.status = ST_PARALLEL;
    end else if (nu6[DOT_W-1] || nu6 > a6) begin
      init.status = ST_U_OUT;
    end else if (nv6[DOT_W-1] || uv_sum > a6) begin
      init.status = ST_V_OUT;
    end else if (nt6[DOT_W-1] || nt6 == '0) begin
      init.status = ST_BEHIND;
    end else begin
      init.status = ST_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvv[0] <= 1'b0;
    end else if (adv) begin
      dvv[0] <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0] <= init;
    end
  end

  // divider chain, quotient bit 30 down to 0
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    rti_div_stage #(.K(DIV_STAGES - 1 - g)) u_stage (
      .clk        (clk),
      .rst        (rst),
      .adv        (adv),
      .din_valid  (dvv[g]),
      .din        (dv[g]),
      .dout_valid (dvv[g+1]),
      .dout       (dv[g+1])
    );
  end

  // result and output skid
  div_t fin;
  logic [T_BITS-1:0] t_val;
  logic [2:0]  r_status;
  logic [31:0] r_t;
  logic [16:0] r_u, r_v;

  always_comb begin
    fin = dv[DIV_STAGES];
    t_val = fin.sat ? {T_BITS{1'b1}} : fin.q_t;
    r_status = fin.status;
    if (fin.status == ST_HIT && t_val <= t_eps) begin
      r_status = ST_BEHIND;
    end
    if (r_status == ST_HIT) begin
      r_t = {1'b0, t_val};
      r_u = fin.q_u;
      r_v = fin.q_v;
    end else begin
      r_t = '0;
      r_u = '0;
      r_v = '0;
    end
  end

  logic        skid_valid;
  logic [2:0]  skid_status;
  logic [31:0] skid_t;
  logic [16:0] skid_u, skid_v;

  assign adv = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (dvv[DIV_STAGES] && adv) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= dvv[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_ready) begin
      if (adv) begin
        skid_status <= r_status;
        skid_t      <= r_t;
        skid_u      <= r_u;
        skid_v      <= r_v;
      end
    end else if (skid_valid) begin
      status       <= skid_status;
      hit_distance <= skid_t;
      weight_u     <= skid_u;
      weight_v     <= skid_v;
    end else begin
      status       <= r_status;
      hit_distance <= r_t;
      weight_u     <= r_u;
      weight_v     <= r_v;
    end
  end

endmodule
